>>> rtl/hptc_pkg.sv
// Shared widths, constants, register indexes and types of the heading PID turn controller.
package hptc_pkg;

  localparam int HEAD_W     = 24;
  localparam int ERR_W      = 25;
  localparam int DER_W      = 26;
  localparam int INTEG_W    = 32;
  localparam int GAIN_W     = 16;
  localparam int ELAP_W     = 17;
  localparam int PROD_W     = 49;
  localparam int ACC_W      = 50;
  localparam int NUM_W      = 29;
  localparam int QUOT_W     = 7;
  localparam int DRV_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int CNT_W      = 3;

  localparam int TICK_MS     = 10;
  localparam int ELAPSED_MAX = 131071;
  localparam int SPEED_DIV   = 2560000;
  localparam int SPEED_MAX   = 127;
  localparam int MUL_LAST    = 3;

  // speed scale 2560000 = 4096 * 625: drop 12 bits, then divide by 625 with a 2^26 reciprocal
  localparam int SCALE_SHIFT = 12;
  localparam int RCP_IN_W    = NUM_W - SCALE_SHIFT;
  localparam int RCP_PROD_W  = 2 * RCP_IN_W;
  localparam int RCP_SHIFT   = 26;
  localparam logic [RCP_IN_W-1:0] RCP_MUL = 17'd107375;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 3'd5;

  localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd223;
  localparam logic [GAIN_W-1:0] WINDOW_RST = 16'd600;

  typedef struct packed {
    logic clr;
    logic vld;
  } mac_ctl_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ERR   = 7'b0000010,
    S_INTEG = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_SCALE = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

endpackage

>>> rtl/hptc_in_if.sv
// Input channel of the heading PID turn controller: heading sample and run restart flag.
interface hptc_in_if;
  import hptc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [HEAD_W-1:0] heading;
  logic                     start_new;

  modport source (output valid, output heading, output start_new, input ready);
  modport sink (input valid, input heading, input start_new, output ready);
endinterface

>>> rtl/hptc_out_if.sv
// Result channel of the heading PID turn controller: motor drives and brake flag.
interface hptc_out_if;
  import hptc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DRV_W-1:0] left_drive;
  logic signed [DRV_W-1:0] right_drive;
  logic                    brake;

  modport source (output valid, output left_drive, output right_drive, output brake,
                  input ready);
  modport sink (input valid, input left_drive, input right_drive, input brake,
                output ready);
endinterface

>>> rtl/heading_pid_turn_controller_unit.sv
// Heading PID turn controller: sequencer, run state, config registers and result register.
// Each item steps through S_ERR, S_INTEG, S_MUL, S_SCALE, S_DIV and S_FIN; once a run has
// finished, items go from S_ERR straight to S_FIN. One item is taken at a time, in S_IDLE.
// Shared multiplier: three products in S_MUL; the constant scale uses S_SCALE and S_DIV.
// The result register lets the next item be accepted while a result waits; a second result
// holds the sequencer until the first leaves. Reset (rst_n low, synchronous) clears run state.
module heading_pid_turn_controller_unit import hptc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  hptc_in_if.sink               in_ch,
  hptc_out_if.source            out_ch
);

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;

  logic signed [HEAD_W-1:0]  target_r;
  logic [GAIN_W-1:0]         timeout_r;
  logic [GAIN_W-1:0]         gain_p_r;
  logic [GAIN_W-1:0]         gain_i_r;
  logic [GAIN_W-1:0]         gain_d_r;
  logic [GAIN_W-1:0]         window_r;

  logic signed [HEAD_W-1:0]  heading_r;
  logic signed [ERR_W-1:0]   e_r;
  logic signed [DER_W-1:0]   d_r;
  logic signed [ERR_W-1:0]   prev_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic [ELAP_W-1:0]         elapsed_r;
  logic                      finished_r;
  logic                      sat_r;
  logic                      neg_r;

  logic                      out_vld_r;
  logic signed [DRV_W-1:0]   out_left_r;
  logic signed [DRV_W-1:0]   out_right_r;
  logic                      out_brake_r;

  logic                      accept;
  logic                      slot_free;
  logic                      fire;
  logic signed [INTEG_W:0]   isum;
  logic signed [INTEG_W-1:0] integ_new;
  logic [ERR_W-1:0]          mag;
  logic                      sign_chg;
  mac_ctl_t                  mac_ctl;
  logic [GAIN_W-1:0]         mac_gain;
  logic signed [INTEG_W-1:0] mac_opnd;
  logic signed [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]          abs_sum;
  logic [NUM_W-1:0]          num;
  logic                      div_done;
  logic [QUOT_W-1:0]         quot;
  logic [QUOT_W-1:0]         spd_mag;
  logic signed [DRV_W-1:0]   speed;
  logic [ELAP_W:0]           elap_sum;
  logic                      timed_out;

  assign accept    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_vld_r || out_ch.ready;
  assign fire      = (state_r == S_FIN) && slot_free;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_ERR;
      end
      S_ERR: begin
        state_nxt = finished_r ? S_FIN : S_INTEG;
      end
      S_INTEG: begin
        state_nxt = S_MUL;
        cnt_nxt   = '0;
      end
      S_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_LAST)) state_nxt = S_SCALE;
      end
      S_SCALE: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= '0;
      timeout_r <= '0;
      gain_p_r  <= GAIN_P_RST;
      gain_i_r  <= '0;
      gain_d_r  <= '0;
      window_r  <= WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TARGET:  target_r  <= $signed(cfg_data[HEAD_W-1:0]);
        REG_TIMEOUT: timeout_r <= cfg_data[GAIN_W-1:0];
        REG_GAIN_P:  gain_p_r  <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:  gain_i_r  <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:  gain_d_r  <= cfg_data[GAIN_W-1:0];
        REG_WINDOW:  window_r  <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // integral update
  always_comb begin
    isum = $signed({integ_r[INTEG_W-1], integ_r})
         + $signed({{(INTEG_W+1-ERR_W){e_r[ERR_W-1]}}, e_r});
    mag  = e_r[ERR_W-1] ? (ERR_W'(0) - e_r) : e_r;
    integ_new = integ_r;
    if (mag < {{(ERR_W-GAIN_W){1'b0}}, window_r}) begin
      if (isum[INTEG_W] != isum[INTEG_W-1]) begin
        integ_new = isum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
      end else begin
        integ_new = isum[INTEG_W-1:0];
      end
    end
    sign_chg = (!e_r[ERR_W-1] && (e_r != '0) && prev_r[ERR_W-1])
            || (e_r[ERR_W-1] && !prev_r[ERR_W-1] && (prev_r != '0));
    if (sign_chg || (e_r == '0)) integ_new = '0;
  end

  // multiplier operand select
  always_comb begin
    mac_ctl.clr = (state_r == S_INTEG);
    mac_ctl.vld = (state_r == S_MUL) && (cnt_r < CNT_W'(MUL_LAST));
    case (cnt_r)
      3'd0: begin
        mac_gain = gain_p_r;
        mac_opnd = {{(INTEG_W-ERR_W){e_r[ERR_W-1]}}, e_r};
      end
      3'd1: begin
        mac_gain = gain_d_r;
        mac_opnd = {{(INTEG_W-DER_W){d_r[DER_W-1]}}, d_r};
      end
      default: begin
        mac_gain = gain_i_r;
        mac_opnd = integ_r;
      end
    endcase
  end

  hptc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .gain  (mac_gain),
    .opnd  (mac_opnd),
    .acc   (acc)
  );

  assign abs_sum = acc[ACC_W-1] ? (ACC_W'(0) - acc) : acc;
  assign num     = {abs_sum[NUM_W-QUOT_W-1:0], {QUOT_W{1'b0}}}
                 - {{QUOT_W{1'b0}}, abs_sum[NUM_W-QUOT_W-1:0]};

  hptc_qdiv u_qdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_SCALE),
    .num   (num),
    .done  (div_done),
    .quot  (quot)
  );

  assign spd_mag   = sat_r ? QUOT_W'(SPEED_MAX) : quot;
  assign speed     = neg_r ? (DRV_W'(0) - {1'b0, spd_mag}) : $signed({1'b0, spd_mag});
  assign elap_sum  = {1'b0, elapsed_r} + (ELAP_W+1)'(TICK_MS);
  assign timed_out = (elapsed_r > {{(ELAP_W-GAIN_W){1'b0}}, timeout_r});

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) heading_r <= in_ch.heading;
      end
      S_ERR: begin
        e_r <= $signed({target_r[HEAD_W-1], target_r}) - $signed({heading_r[HEAD_W-1], heading_r});
      end
      S_INTEG: begin
        d_r <= $signed({e_r[ERR_W-1], e_r}) - $signed({prev_r[ERR_W-1], prev_r});
      end
      S_SCALE: begin
        sat_r <= (abs_sum >= ACC_W'(SPEED_DIV));
        neg_r <= acc[ACC_W-1];
      end
      default: begin
      end
    endcase
  end

  // run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      integ_r    <= '0;
      elapsed_r  <= '0;
      finished_r <= 1'b0;
    end else if (accept && in_ch.start_new) begin
      prev_r     <= '0;
      integ_r    <= '0;
      elapsed_r  <= '0;
      finished_r <= 1'b0;
    end else if (state_r == S_INTEG) begin
      prev_r  <= e_r;
      integ_r <= integ_new;
    end else if (fire && !finished_r) begin
      if (timed_out) begin
        finished_r <= 1'b1;
      end else if (elap_sum > (ELAP_W+1)'(ELAPSED_MAX)) begin
        elapsed_r <= ELAP_W'(ELAPSED_MAX);
      end else begin
        elapsed_r <= elap_sum[ELAP_W-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (finished_r || timed_out) begin
        out_left_r  <= '0;
        out_right_r <= '0;
        out_brake_r <= 1'b1;
      end else begin
        out_left_r  <= speed;
        out_right_r <= DRV_W'(0) - speed;
        out_brake_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.left_drive  = out_left_r;
  assign out_ch.right_drive = out_right_r;
  assign out_ch.brake       = out_brake_r;

  a_brake_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.brake |-> out_ch.left_drive == '0 && out_ch.right_drive == '0)
    else $error("brake item carries nonzero drive");

  a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.right_drive == DRV_W'(0) - out_ch.left_drive)
    else $error("right drive is not the negated left drive");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.left_drive != {1'b1, {(DRV_W-1){1'b0}}})
    else $error("drive outside saturation range");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("item accepted while previous item in progress");

  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(finished_r) |-> out_vld_r && out_brake_r)
    else $error("timeout reached without brake item");

endmodule

>>> rtl/hptc_mac.sv
// Shared gain multiplier with registered product and signed accumulator.
module hptc_mac import hptc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mac_ctl_t                  ctl,
  input  logic        [GAIN_W-1:0]  gain,
  input  logic signed [INTEG_W-1:0] opnd,
  output logic signed [ACC_W-1:0]   acc
);

  logic signed [PROD_W-1:0] prod_r;
  logic                     pvld_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [GAIN_W:0]   gain_s;

  assign gain_s = $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    prod_r <= gain_s * opnd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
      acc_r  <= '0;
    end else begin
      pvld_r <= ctl.vld;
      if (ctl.clr) begin
        acc_r <= '0;
      end else if (pvld_r) begin
        acc_r <= acc_r + $signed({{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r});
      end
    end
  end

  assign acc = acc_r;

endmodule

>>> rtl/hptc_qdiv.sv
// Constant speed-scale divider: reciprocal multiply with registered operand and quotient.
module hptc_qdiv import hptc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  output logic              done,
  output logic [QUOT_W-1:0] quot
);

  logic [RCP_IN_W-1:0]   y_r;
  logic                  busy_r;
  logic [QUOT_W-1:0]     quot_r;
  logic [RCP_PROD_W-1:0] prod;

  assign prod = y_r * RCP_MUL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      y_r <= num[NUM_W-1:SCALE_SHIFT];
    end
    if (busy_r) begin
      quot_r <= prod[RCP_SHIFT+QUOT_W-1:RCP_SHIFT];
    end
  end

  assign done = busy_r;
  assign quot = quot_r;

endmodule

>>> verif/heading_pid_turn_controller_unit_checker.sv
// Scoreboard for the heading PID turn controller: tracks registers, predicts and checks drive items.
module heading_pid_turn_controller_unit_checker import hptc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  hptc_in_if                    in_ch,
  hptc_out_if                   out_ch,
  output int                    fail_count,
  output int                    pending,
  output int                    result_count,
  output int                    brake_count
);

  localparam int     REPORT_MAX = 10;
  localparam longint INTEG_HI   = (64'sd1 <<< (INTEG_W - 1)) - 1;
  localparam longint INTEG_LO   = -(64'sd1 <<< (INTEG_W - 1));

  typedef struct packed {
    logic signed [DRV_W-1:0] left_drive;
    logic signed [DRV_W-1:0] right_drive;
    logic                    brake;
  } drive_t;

  logic signed [HEAD_W-1:0]  target_cd;
  logic [GAIN_W-1:0]         timeout_lim;
  logic [GAIN_W-1:0]         kp;
  logic [GAIN_W-1:0]         ki;
  logic [GAIN_W-1:0]         kd;
  logic [GAIN_W-1:0]         win;
  logic signed [ERR_W-1:0]   last_err;
  logic signed [INTEG_W-1:0] err_sum;
  int unsigned               run_ms;
  logic                      braked;
  drive_t                    drive_q[$];
  int                        mismatches   = 0;
  int                        results_seen = 0;
  int                        brakes_seen  = 0;

  task automatic steer_tick(input logic signed [HEAD_W-1:0] hdg, input logic restart,
                            output drive_t cmd);
    longint err;
    longint slope;
    longint acc;
    longint mag;
    longint sum;
    longint speed;
    cmd.left_drive  = '0;
    cmd.right_drive = '0;
    cmd.brake       = 1'b1;
    if (restart) begin
      last_err = '0;
      err_sum  = '0;
      run_ms   = 0;
      braked   = 1'b0;
    end
    if (!braked) begin
      err   = longint'(target_cd) - longint'(hdg);
      slope = err - longint'(last_err);
      acc   = longint'(err_sum);
      mag   = (err < 0) ? -err : err;
      if (mag < longint'(win)) begin
        acc = acc + err;
        if (acc > INTEG_HI) acc = INTEG_HI;
        if (acc < INTEG_LO) acc = INTEG_LO;
      end
      if ((err > 0 && last_err < 0) || (err < 0 && last_err > 0) || err == 0) acc = 0;
      last_err = ERR_W'(err);
      err_sum  = INTEG_W'(acc);
      sum   = longint'(kp) * err + longint'(kd) * slope + longint'(ki) * acc;
      speed = (sum * longint'(SPEED_MAX)) / longint'(SPEED_DIV);
      if (speed > SPEED_MAX) speed = SPEED_MAX;
      if (speed < -SPEED_MAX) speed = -SPEED_MAX;
      if (run_ms > timeout_lim) begin
        braked = 1'b1;
      end else begin
        run_ms = run_ms + TICK_MS;
        if (run_ms > ELAPSED_MAX) run_ms = ELAPSED_MAX;
        cmd.left_drive  = DRV_W'(speed);
        cmd.right_drive = DRV_W'(-speed);
        cmd.brake       = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin
    drive_t want;
    drive_t got;
    if (!rst_n) begin
      target_cd   = '0;
      timeout_lim = '0;
      kp          = GAIN_P_RST;
      ki          = '0;
      kd          = '0;
      win         = WINDOW_RST;
      last_err    = '0;
      err_sum     = '0;
      run_ms      = 0;
      braked      = 1'b0;
      drive_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_TARGET:  target_cd   = signed'(cfg_data[HEAD_W-1:0]);
          REG_TIMEOUT: timeout_lim = cfg_data[GAIN_W-1:0];
          REG_GAIN_P:  kp          = cfg_data[GAIN_W-1:0];
          REG_GAIN_I:  ki          = cfg_data[GAIN_W-1:0];
          REG_GAIN_D:  kd          = cfg_data[GAIN_W-1:0];
          REG_WINDOW:  win         = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got.left_drive  = out_ch.left_drive;
        got.right_drive = out_ch.right_drive;
        got.brake       = out_ch.brake;
        results_seen++;
        if (got.brake) brakes_seen++;
        if (drive_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected drive item %0d: left %0d right %0d brake %0b",
                     results_seen, got.left_drive, got.right_drive, got.brake);
        end else begin
          want = drive_q.pop_front();
          if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive ||
              got.brake !== want.brake) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("drive item %0d: expected left %0d right %0d brake %0b, got left %0d right %0d brake %0b",
                       results_seen, want.left_drive, want.right_drive, want.brake,
                       got.left_drive, got.right_drive, got.brake);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        steer_tick(in_ch.heading, in_ch.start_new, want);
        drive_q.push_back(want);
      end
    end
    fail_count   <= mismatches;
    pending      <= drive_q.size();
    result_count <= results_seen;
    brake_count  <= brakes_seen;
  end

endmodule

>>> verif/heading_pid_turn_controller_unit_tb.sv
// Testbench top for the heading PID turn controller: clock, reset, register setup, stimulus, verdict.
module heading_pid_turn_controller_unit_tb;
  import hptc_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int SEGMENTS      = 9;
  localparam int SEGMENT_ITEMS = 170;
  localparam int GAP_CAP       = 50;
  localparam int HOLD_SEGMENT  = 6;
  localparam int MAX_SEGMENT   = 0;
  localparam int MIN_SEGMENT   = 4;

  localparam logic [CFG_IDX_W-1:0]     REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0]     REG_SPARE_HI = 3'd7;
  localparam logic signed [HEAD_W-1:0] HEAD_MAX     = {1'b0, {(HEAD_W-1){1'b1}}};
  localparam logic signed [HEAD_W-1:0] HEAD_MIN     = {1'b1, {(HEAD_W-1){1'b0}}};
  localparam logic [GAIN_W-1:0]        U16_MAX      = '1;
  localparam logic [GAIN_W-1:0]        U16_ZERO     = '0;

  typedef enum int {
    IDLE_SLOW_SINK,
    IDLE_SLOW_SOURCE,
    IDLE_NONE
  } idling_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_idx;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     hold_off;
  int                       send_gap_pct;
  int                       recv_stall_pct;
  int                       fail_count;
  int                       pending;
  int                       result_count;
  int                       brake_count;
  int                       samples_sent;
  int                       restarts_sent;
  int                       settings_loaded;
  int                       cycles;
  int                       seg;
  logic signed [HEAD_W-1:0] cur_target;

  hptc_in_if  in_ch ();
  hptc_out_if out_ch ();

  heading_pid_turn_controller_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  heading_pid_turn_controller_unit_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count),
    .brake_count  (brake_count)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d drive items still due", cycles, pending);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [CFG_DATA_W-1:0] with_junk_top(input logic [GAIN_W-1:0] v);
    logic [CFG_DATA_W-1:0] w;
    w = CFG_DATA_W'($urandom);
    w[GAIN_W-1:0] = v;
    return w;
  endfunction

  task automatic set_idling(input idling_t mode);
    case (mode)
      IDLE_SLOW_SINK: begin
        send_gap_pct   <= 6;
        recv_stall_pct <= 87;
      end
      IDLE_SLOW_SOURCE: begin
        send_gap_pct   <= 87;
        recv_stall_pct <= 6;
      end
      default: begin
        send_gap_pct   <= 0;
        recv_stall_pct <= 0;
      end
    endcase
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic signed [HEAD_W-1:0] tgt, input logic [GAIN_W-1:0] tmo,
                               input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gi,
                               input logic [GAIN_W-1:0] gd, input logic [GAIN_W-1:0] win);
    put_reg(REG_TARGET, tgt);
    put_reg(REG_TIMEOUT, with_junk_top(tmo));
    put_reg(REG_GAIN_P, with_junk_top(gp));
    put_reg(REG_GAIN_I, with_junk_top(gi));
    put_reg(REG_GAIN_D, with_junk_top(gd));
    put_reg(REG_WINDOW, with_junk_top(win));
    put_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
    put_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    cur_target = tgt;
    settings_loaded++;
  endtask

  task automatic offer_sample(input logic signed [HEAD_W-1:0] hdg, input logic restart);
    int idle;
    in_ch.valid     <= 1'b1;
    in_ch.heading   <= hdg;
    in_ch.start_new <= restart;
    do @(posedge clk); while (!in_ch.ready);
    samples_sent++;
    if (restart) restarts_sent++;
    idle = 0;
    while (idle < GAP_CAP && $urandom_range(99) < send_gap_pct) idle++;
    if (idle > 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  task automatic settle_block();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    // reset settings: zero timeout brakes on the second tick
    offer_sample('0, 1'b0);
    offer_sample(24'sd100, 1'b0);
    offer_sample(-24'sd100, 1'b0);
    offer_sample(24'sd5, 1'b1);
    settle_block();
    load_settings(HEAD_MAX, U16_MAX, U16_MAX, U16_MAX, U16_MAX, 16'd600);
    offer_sample(HEAD_MIN, 1'b1);
    offer_sample(HEAD_MAX, 1'b0);
    offer_sample(HEAD_MAX - 24'sd599, 1'b0);
    offer_sample(HEAD_MAX - 24'sd600, 1'b0);
    offer_sample(HEAD_MAX - 24'sd601, 1'b0);
    settle_block();
    // sign flips, window edge, zero error, timeout tick, braked ticks, restart
    load_settings('0, 16'd40, 16'd223, 16'd4096, 16'd1024, 16'd600);
    offer_sample(24'sd100, 1'b1);
    offer_sample(-24'sd100, 1'b0);
    offer_sample(-24'sd599, 1'b0);
    offer_sample(24'sd600, 1'b0);
    offer_sample('0, 1'b0);
    offer_sample(24'sd7, 1'b0);
    offer_sample(24'sd8, 1'b0);
    offer_sample(24'sd9, 1'b1);
    settle_block();
    load_settings(HEAD_MIN, U16_MAX, U16_MAX, U16_ZERO, U16_MAX, U16_MAX);
    offer_sample(HEAD_MAX, 1'b1);
    offer_sample(HEAD_MIN, 1'b0);
  endtask

  task automatic run_turns(input int n);
    int     done;
    int     len;
    int     spread;
    int     k;
    longint err;
    done = 0;
    while (done < n) begin
      if ($urandom_range(99) < 85) begin
        len    = $urandom_range(50, 1);
        spread = ($urandom_range(3) == 0) ? $urandom_range(8388607) : $urandom_range(4000);
        err    = $urandom_range(1) ? spread : -spread;
        for (k = 0; k < len && done < n; k++) begin
          offer_sample(HEAD_W'(longint'(cur_target) - err), k == 0);
          done++;
          err = err - err / 4 + (int'($urandom_range(200)) - 100);
          if ($urandom_range(9) == 0) err = -err / 2;
          if ($urandom_range(14) == 0) err = 0;
        end
      end else begin
        offer_sample(HEAD_W'($urandom), $urandom_range(3) == 0);
        done++;
      end
    end
  endtask

  task automatic pick_settings(input int idx);
    logic [GAIN_W-1:0] tmo;
    logic [GAIN_W-1:0] gp;
    logic [GAIN_W-1:0] gi;
    logic [GAIN_W-1:0] gd;
    logic [GAIN_W-1:0] win;
    if (idx == MAX_SEGMENT) begin
      load_settings(HEAD_MAX, U16_MAX, U16_MAX, U16_MAX, U16_MAX, U16_MAX);
    end else if (idx == MIN_SEGMENT) begin
      load_settings(HEAD_MIN, U16_ZERO, U16_ZERO, U16_ZERO, U16_ZERO, U16_ZERO);
    end else begin
      tmo = GAIN_W'(($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(400));
      gp  = GAIN_W'($urandom_range(1) ? $urandom_range(2047) : $urandom_range(65535));
      gi  = GAIN_W'($urandom_range(1) ? $urandom_range(255) : $urandom_range(65535));
      gd  = GAIN_W'($urandom_range(1) ? $urandom_range(2047) : $urandom_range(65535));
      win = GAIN_W'(($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(2000));
      load_settings(HEAD_W'($urandom), tmo, gp, gi, gd, win);
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= '0;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.heading   <= '0;
    in_ch.start_new <= 1'b0;
    hold_off        <= 1'b0;
    set_idling(IDLE_SLOW_SINK);
    cur_target      = '0;
    samples_sent    = 0;
    restarts_sent   = 0;
    settings_loaded = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (seg = 0; seg < SEGMENTS; seg++) begin
      settle_block();
      set_idling(idling_t'(seg / 3));
      pick_settings(seg);
      if (seg == HOLD_SEGMENT) begin
        fork
          begin
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      run_turns(SEGMENT_ITEMS);
    end
    settle_block();
    $display("sent %0d heading samples (%0d restarts) under %0d register settings",
             samples_sent, restarts_sent, settings_loaded);
    $display("checked %0d drive items, %0d of them braking, %0d mismatches",
             result_count, brake_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/hptc_pkg.sv
rtl/hptc_in_if.sv
rtl/hptc_out_if.sv
rtl/hptc_mac.sv
rtl/hptc_qdiv.sv
rtl/heading_pid_turn_controller_unit.sv
verif/heading_pid_turn_controller_unit_checker.sv
verif/heading_pid_turn_controller_unit_tb.sv
